[sv/cgw_pkg.sv]
// shared types, constants and the band lookup for the capacitive gesture window classifier
// used by every module of the block; depends on nothing else
package cgw_pkg;

    localparam int TRIPLES_PER_SAMPLE = 4;
    localparam int BAND_SLOTS         = 6;

    localparam int TC_W      = (TRIPLES_PER_SAMPLE > 1) ? $clog2(TRIPLES_PER_SAMPLE) : 1;
    localparam int SUM_W     = 16 + TC_W;
    localparam int BAND_W    = 3;
    localparam int MAX_BANDS = (BAND_SLOTS - 1 < 5) ? BAND_SLOTS - 1 : 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 16;

    localparam logic [15:0] ONE_PF      = 16'd1024;
    localparam logic [15:0] SIX_PF      = 16'd6144;
    // ceil(2^18 / 5), exact floor division by five for magnitudes below 2^18
    localparam logic [15:0] RECIP_FIVE  = 16'd52429;
    localparam int          RECIP_SHIFT = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIN_COUNT       = 3'd0,
        REG_BOUNDARY_ONE    = 3'd1,
        REG_BOUNDARY_TWO    = 3'd2,
        REG_BOUNDARY_THREE  = 3'd3,
        REG_BOUNDARY_FOUR   = 3'd4,
        REG_BASELINE_OFFSET = 3'd5,
        REG_WINDOW_LEN      = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [2:0]  bin_count;
        logic [15:0] boundary_one;
        logic [15:0] boundary_two;
        logic [15:0] boundary_three;
        logic [15:0] boundary_four;
        logic [15:0] baseline_offset;
        logic [7:0]  window_len;
    } cfg_t;

    typedef struct packed {
        logic [15:0] reading_a;
        logic [15:0] reading_b;
        logic [15:0] reading_c;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] filtered_sample;
        logic               decision_valid;
        logic [BAND_W-1:0]  gesture_class;
    } out_item_t;

    // band 1..n when strictly inside its edges, lowest match first, else 0
    function automatic logic [BAND_W-1:0] pick_band(input logic signed [15:0] v,
                                                     input cfg_t cfg);
        logic [2:0]          n;
        logic [5:0][15:0]    edges;
        logic signed [16:0]  vx;
        logic [BAND_W-1:0]   band;
        n = cfg.bin_count;
        if (n < 3'd2) n = 3'd2;
        if (n > 3'(MAX_BANDS)) n = 3'(MAX_BANDS);
        edges[0] = ONE_PF;
        edges[1] = cfg.boundary_one;
        edges[2] = cfg.boundary_two;
        edges[3] = cfg.boundary_three;
        edges[4] = cfg.boundary_four;
        edges[5] = 16'd0;
        edges[n] = SIX_PF;
        vx = {v[15], v};
        band = '0;
        for (int k = MAX_BANDS; k >= 1; k--) begin
            if (3'(k) <= n && vx > $signed({1'b0, edges[k-1]})
                    && vx < $signed({1'b0, edges[k]})) begin
                band = BAND_W'(k);
            end
        end
        return band;
    endfunction

endpackage

[sv/cgw_front.sv]
// input register, median of three and per-sample averaging with offset and saturation
// depends on cgw_pkg
module cgw_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  cgw_pkg::cfg_t      cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  cgw_pkg::in_item_t  s_data,
    output logic               cur_valid,
    input  logic               cur_ready,
    output logic signed [15:0] cur_sample
);
    import cgw_pkg::*;

    logic               in_vld_reg;
    in_item_t           in_data_reg;
    logic [TC_W-1:0]    tc_reg, tc_next;
    logic [SUM_W-1:0]   sum_reg, sum_next, sum_full;
    logic               cur_vld_reg;
    logic signed [15:0] cur_reg, cur_next;
    logic               a_fire, last;
    logic [15:0]        lo, hi, med, avg;
    logic signed [16:0] diff;

    assign a_fire  = in_vld_reg && (!cur_vld_reg || cur_ready);
    assign s_ready = !in_vld_reg || a_fire;

    always_comb begin
        lo = (in_data_reg.reading_a < in_data_reg.reading_b) ?
             in_data_reg.reading_a : in_data_reg.reading_b;
        hi = (in_data_reg.reading_a < in_data_reg.reading_b) ?
             in_data_reg.reading_b : in_data_reg.reading_a;
        if (in_data_reg.reading_c > hi) begin
            med = hi;
        end else if (in_data_reg.reading_c > lo) begin
            med = in_data_reg.reading_c;
        end else begin
            med = lo;
        end
        last     = (tc_reg == TC_W'(TRIPLES_PER_SAMPLE - 1));
        sum_full = sum_reg + SUM_W'(med);
        avg      = 16'(sum_full / TRIPLES_PER_SAMPLE);
        diff     = $signed({1'b0, avg}) - $signed({1'b0, cfg.baseline_offset});
        if (diff > 17'sd32767) begin
            cur_next = 16'sh7fff;
        end else if (diff < -17'sd32768) begin
            cur_next = 16'sh8000;
        end else begin
            cur_next = diff[15:0];
        end
        tc_next  = last ? '0 : tc_reg + 1'b1;
        sum_next = last ? '0 : sum_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            cur_vld_reg <= 1'b0;
            tc_reg      <= '0;
            sum_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (a_fire) begin
                in_vld_reg <= 1'b0;
            end
            if (a_fire) begin
                tc_reg  <= tc_next;
                sum_reg <= sum_next;
            end
            if (a_fire && last) begin
                cur_vld_reg <= 1'b1;
            end else if (cur_ready) begin
                cur_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (a_fire && last) begin
            cur_reg <= cur_next;
        end
    end

    assign cur_valid  = cur_vld_reg;
    assign cur_sample = cur_reg;

endmodule

[sv/cgw_smooth.sv]
// smoothing stage: (prev + 4*cur)/5 truncated toward zero, by reciprocal multiply
// depends on cgw_pkg
module cgw_smooth (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cur_valid,
    output logic               cur_ready,
    input  logic signed [15:0] cur_sample,
    output logic               filt_valid,
    input  logic               filt_ready,
    output logic signed [15:0] filt_sample
);
    import cgw_pkg::*;

    logic signed [15:0] prev_reg, filt_next, filt_reg;
    logic               filt_vld_reg, b_fire, neg;
    logic signed [18:0] total;
    logic [18:0]        total_neg;
    logic [17:0]        mag;
    logic [33:0]        prod;
    logic [15:0]        quot;

    assign cur_ready = !filt_vld_reg || filt_ready;
    assign b_fire    = cur_valid && cur_ready;

    always_comb begin
        total     = {{3{prev_reg[15]}}, prev_reg} + {{1{cur_sample[15]}}, cur_sample, 2'b00};
        neg       = total[18];
        total_neg = 19'd0 - total;
        mag       = neg ? total_neg[17:0] : total[17:0];
        prod      = 34'(mag) * 34'(RECIP_FIVE);
        quot      = prod[RECIP_SHIFT +: 16];
        filt_next = neg ? 16'(16'd0 - quot) : quot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            filt_vld_reg <= 1'b0;
        end else begin
            if (b_fire) begin
                prev_reg     <= filt_next;
                filt_vld_reg <= 1'b1;
            end else if (filt_ready) begin
                filt_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            filt_reg <= filt_next;
        end
    end

    assign filt_valid  = filt_vld_reg;
    assign filt_sample = filt_reg;

endmodule

[sv/cgw_vote.sv]
// band counting over a voting window, argmax with lowest index on ties, result register
// depends on cgw_pkg
module cgw_vote (
    input  logic                aclk,
    input  logic                aresetn,
    input  cgw_pkg::cfg_t       cfg,
    input  logic                filt_valid,
    output logic                filt_ready,
    input  logic signed [15:0]  filt_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output cgw_pkg::out_item_t  m_data
);
    import cgw_pkg::*;

    logic [BAND_SLOTS-1:0][7:0] cnt_reg, cnt_inc;
    logic [7:0]                 sample_cnt_reg, sc_inc, wl, best_cnt;
    logic [BAND_W-1:0]          band, best;
    logic                       m_vld_reg, c_fire, done, cnt_all_zero;
    out_item_t                  out_reg, out_next;

    assign filt_ready = !m_vld_reg || m_ready;
    assign c_fire     = filt_valid && filt_ready;

    always_comb begin
        band = pick_band(filt_sample, cfg);
        for (int i = 0; i < BAND_SLOTS; i++) begin
            if (band == BAND_W'(i) && cnt_reg[i] != 8'hff) begin
                cnt_inc[i] = cnt_reg[i] + 8'd1;
            end else begin
                cnt_inc[i] = cnt_reg[i];
            end
        end
        best     = '0;
        best_cnt = cnt_inc[0];
        for (int i = 1; i < BAND_SLOTS; i++) begin
            if (cnt_inc[i] > best_cnt) begin
                best     = BAND_W'(i);
                best_cnt = cnt_inc[i];
            end
        end
        sc_inc = sample_cnt_reg + 8'd1;
        wl     = (cfg.window_len == 8'd0) ? 8'd1 : cfg.window_len;
        done   = (sc_inc == 8'd0) || (sc_inc >= wl);
        out_next.filtered_sample = filt_sample;
        out_next.decision_valid  = done;
        out_next.gesture_class   = done ? best : '0;
        cnt_all_zero = 1'b1;
        for (int i = 0; i < BAND_SLOTS; i++) begin
            if (cnt_reg[i] != 8'd0) cnt_all_zero = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            sample_cnt_reg <= '0;
            m_vld_reg      <= 1'b0;
        end else begin
            if (c_fire) begin
                m_vld_reg <= 1'b1;
                if (done) begin
                    cnt_reg        <= '0;
                    sample_cnt_reg <= '0;
                end else begin
                    cnt_reg        <= cnt_inc;
                    sample_cnt_reg <= sc_inc;
                end
            end else if (m_ready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = out_reg;

    a_class_zero_without_decision: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.decision_valid |-> m_data.gesture_class == '0)
        else $error("gesture class set without a decision");

    a_class_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.gesture_class <= BAND_W'(BAND_SLOTS - 1))
        else $error("gesture class beyond band slots");

    a_window_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        c_fire && done |=> cnt_all_zero && sample_cnt_reg == 8'd0)
        else $error("counters not cleared after a decision");

    a_window_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        c_fire && !done |=> sample_cnt_reg != 8'd0)
        else $error("sample count did not advance inside a window");

endmodule

[sv/capacitive_gesture_window_classifier.sv]
// top level of the capacitive gesture window classifier: configuration registers and stages
// depends on cgw_pkg, cgw_front, cgw_smooth, cgw_vote
//
//   channel | ports                         | payload
//   --------+-------------------------------+------------------------------------------
//   input   | s_valid, s_ready, s_data      | reading_a, reading_b, reading_c
//   result  | m_valid, m_ready, m_data      | filtered_sample, decision_valid, gesture_class
//   config  | cfg_wr_en, cfg_index, cfg_wdata | seven registers, one written per write
//
// one input transaction per cycle while m_ready does not stall; every fourth one yields a result transaction
// from input accept to result valid an item passes the average, smooth and vote regs, which
// follow the input reg
// the smoothing register and the band counters update once per sample in their own stage
// a stall on m_ready backs up stage by stage; s_ready drops only when all stages are full
// synchronous active-low reset clears counters, state and valids and loads register defaults
module capacitive_gesture_window_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cgw_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cgw_pkg::out_item_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [cgw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cgw_pkg::CFG_DW-1:0]      cfg_wdata
);
    import cgw_pkg::*;

    cfg_t               cfg_reg;
    logic               cur_valid, cur_ready, filt_valid, filt_ready;
    logic signed [15:0] cur_sample, filt_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bin_count       <= 3'd3;
            cfg_reg.boundary_one    <= 16'd2765;
            cfg_reg.boundary_two    <= 16'd3994;
            cfg_reg.boundary_three  <= 16'd6144;
            cfg_reg.boundary_four   <= 16'd6144;
            cfg_reg.baseline_offset <= 16'd0;
            cfg_reg.window_len      <= 8'd20;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BIN_COUNT:       cfg_reg.bin_count       <= cfg_wdata[2:0];
                REG_BOUNDARY_ONE:    cfg_reg.boundary_one    <= cfg_wdata;
                REG_BOUNDARY_TWO:    cfg_reg.boundary_two    <= cfg_wdata;
                REG_BOUNDARY_THREE:  cfg_reg.boundary_three  <= cfg_wdata;
                REG_BOUNDARY_FOUR:   cfg_reg.boundary_four   <= cfg_wdata;
                REG_BASELINE_OFFSET: cfg_reg.baseline_offset <= cfg_wdata;
                REG_WINDOW_LEN:      cfg_reg.window_len      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    cgw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cur_valid  (cur_valid),
        .cur_ready  (cur_ready),
        .cur_sample (cur_sample)
    );

    cgw_smooth u_smooth (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cur_valid   (cur_valid),
        .cur_ready   (cur_ready),
        .cur_sample  (cur_sample),
        .filt_valid  (filt_valid),
        .filt_ready  (filt_ready),
        .filt_sample (filt_sample)
    );

    cgw_vote u_vote (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .filt_valid  (filt_valid),
        .filt_ready  (filt_ready),
        .filt_sample (filt_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[verif/tb_capacitive_gesture_window_classifier.sv]
// self-checking testbench for capacitive_gesture_window_classifier
// predicts each sample, band vote and decision in-bench and checks every result transaction
// depends on cgw_pkg and the classifier rtl
module tb_capacitive_gesture_window_classifier;
    import cgw_pkg::*;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PIPE_DRAIN      = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DW-1:0]    cfg_wdata;

    capacitive_gesture_window_classifier DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // in-bench copy of the classifier state and registers
    cfg_t        model_cfg;
    int unsigned triples_held;
    int unsigned median_acc;
    int          prev_filt;
    int unsigned samples_in_window;
    int unsigned band_tally [BAND_SLOTS];

    out_item_t   pending_samples [$];
    out_item_t   oldest_sample;
    int          mismatches;
    int          idle_cycles;
    bit          no_idle;
    bit          hold_off_req;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void reset_model();
        model_cfg.bin_count       = 3'd3;
        model_cfg.boundary_one    = 16'd2765;
        model_cfg.boundary_two    = 16'd3994;
        model_cfg.boundary_three  = 16'd6144;
        model_cfg.boundary_four   = 16'd6144;
        model_cfg.baseline_offset = 16'd0;
        model_cfg.window_len      = 8'd20;
        triples_held      = 0;
        median_acc        = 0;
        prev_filt         = 0;
        samples_in_window = 0;
        for (int i = 0; i < BAND_SLOTS; i++) band_tally[i] = 0;
    endfunction

    function automatic logic [15:0] median_of(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c > hi) return hi;
        if (c > lo) return c;
        return lo;
    endfunction

    // strictly between neighboring edges, lowest band first; edges and misses go to band 0
    function automatic logic [2:0] band_for(int v);
        int edges [6];
        int n;
        n = model_cfg.bin_count;
        if (n < 2) n = 2;
        if (n > 5) n = 5;
        if (n > BAND_SLOTS - 1) n = BAND_SLOTS - 1;
        edges[0] = ONE_PF;
        edges[1] = model_cfg.boundary_one;
        edges[2] = model_cfg.boundary_two;
        edges[3] = model_cfg.boundary_three;
        edges[4] = model_cfg.boundary_four;
        edges[5] = 0;
        edges[n] = SIX_PF;
        for (int k = 1; k <= n; k++) begin
            if (v > edges[k-1] && v < edges[k]) return 3'(k);
        end
        return 3'd0;
    endfunction

    function automatic void absorb_triple(in_item_t t);
        int        cur;
        int        filt;
        int        offset_val;
        int        wl;
        int        best;
        logic [2:0] band;
        bit        done;
        out_item_t sample;
        median_acc += median_of(t.reading_a, t.reading_b, t.reading_c);
        triples_held++;
        if (triples_held < TRIPLES_PER_SAMPLE) return;
        offset_val = model_cfg.baseline_offset;
        cur = int'(median_acc / TRIPLES_PER_SAMPLE) - offset_val;
        triples_held = 0;
        median_acc   = 0;
        if (cur > 32767) cur = 32767;
        if (cur < -32768) cur = -32768;
        filt = (prev_filt + 4 * cur) / 5;
        prev_filt = filt;
        band = band_for(filt);
        if (band < BAND_SLOTS && band_tally[band] < 255) band_tally[band]++;
        samples_in_window = (samples_in_window + 1) & 8'hFF;
        wl = (model_cfg.window_len == 8'd0) ? 1 : model_cfg.window_len;
        done = (samples_in_window == 0) || (samples_in_window >= wl);
        best = 0;
        if (done) begin
            for (int i = 1; i < BAND_SLOTS; i++) begin
                if (band_tally[i] > band_tally[best]) best = i;
            end
            for (int i = 0; i < BAND_SLOTS; i++) band_tally[i] = 0;
            samples_in_window = 0;
        end
        sample.filtered_sample = 16'(filt);
        sample.decision_valid  = done;
        sample.gesture_class   = 3'(best);
        pending_samples.push_back(sample);
    endfunction

    function automatic int idle_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one input transaction; valid stays up across back-to-back items
    task automatic offer_readings(input in_item_t item);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        absorb_triple(item);
    endtask

    // wait until every sample is back, then let the pipe drain; partial triples stay accumulated
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // narrow registers get junk in the unused upper bits
    task automatic program_registers(input cfg_t c);
        write_reg(REG_BIN_COUNT, {13'($urandom), c.bin_count});
        write_reg(REG_BOUNDARY_ONE, c.boundary_one);
        write_reg(REG_BOUNDARY_TWO, c.boundary_two);
        write_reg(REG_BOUNDARY_THREE, c.boundary_three);
        write_reg(REG_BOUNDARY_FOUR, c.boundary_four);
        write_reg(REG_BASELINE_OFFSET, c.baseline_offset);
        write_reg(REG_WINDOW_LEN, {8'($urandom), c.window_len});
        cfg_wr_en <= 1'b0;
        model_cfg = c;
    endtask

    function automatic cfg_t random_settings();
        cfg_t        c;
        logic [15:0] b [4];
        logic [15:0] swap;
        int          mode;
        int          r;
        c.bin_count = 3'($urandom_range(0, 7));
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++) begin
            if (mode < 6) begin
                b[i] = 16'($urandom_range(ONE_PF, SIX_PF));
            end else if (mode < 8) begin
                b[i] = 16'($urandom);
            end else begin
                case ($urandom_range(0, 3))
                    0: b[i] = 16'h0000;
                    1: b[i] = 16'hFFFF;
                    2: b[i] = ONE_PF;
                    default: b[i] = SIX_PF;
                endcase
            end
        end
        // ordered edges most of the time, unordered ones otherwise
        if (mode < 6) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3 - i; j++) begin
                    if (b[j] > b[j+1]) begin
                        swap = b[j];
                        b[j] = b[j+1];
                        b[j+1] = swap;
                    end
                end
            end
        end
        c.boundary_one   = b[0];
        c.boundary_two   = b[1];
        c.boundary_three = b[2];
        c.boundary_four  = b[3];
        r = $urandom_range(0, 9);
        if (r < 5) c.baseline_offset = 16'd0;
        else if (r < 8) c.baseline_offset = 16'($urandom_range(0, 2048));
        else c.baseline_offset = 16'($urandom);
        r = $urandom_range(0, 9);
        if (r < 6) c.window_len = 8'($urandom_range(1, 8));
        else if (r == 6) c.window_len = 8'd0;
        else if (r < 9) c.window_len = 8'($urandom_range(9, 40));
        else c.window_len = 8'd255;
        return c;
    endfunction

    // raw reading whose offset-corrected value mostly lands on or near a band edge, else anywhere
    function automatic int pick_reading();
        int edge_val;
        int jitter;
        int desired;
        int reading;
        case ($urandom_range(0, 9))
            6, 7, 8: desired = $urandom_range(0, 8191);
            9:       desired = $urandom_range(0, 65535);
            default: begin
                case ($urandom_range(0, 5))
                    0: edge_val = ONE_PF;
                    1: edge_val = SIX_PF;
                    2: edge_val = model_cfg.boundary_one;
                    3: edge_val = model_cfg.boundary_two;
                    4: edge_val = model_cfg.boundary_three;
                    default: edge_val = model_cfg.boundary_four;
                endcase
                jitter  = $urandom_range(0, 4);
                desired = edge_val + jitter - 2;
            end
        endcase
        reading = desired + int'(model_cfg.baseline_offset);
        if (reading < 0) reading = 0;
        if (reading > 65535) reading = 65535;
        return reading;
    endfunction

    function automatic in_item_t make_triple(int median_val);
        in_item_t    t;
        logic [15:0] mid;
        logic [15:0] lo;
        logic [15:0] hi;
        if ($urandom_range(0, 9) == 0) begin
            t.reading_a = 16'($urandom);
            t.reading_b = 16'($urandom);
            t.reading_c = 16'($urandom);
            return t;
        end
        mid = 16'(median_val);
        lo  = 16'($urandom_range(0, mid));
        hi  = 16'($urandom_range(mid, 65535));
        case ($urandom_range(0, 5))
            0: t = '{lo, mid, hi};
            1: t = '{lo, hi, mid};
            2: t = '{mid, lo, hi};
            3: t = '{mid, hi, lo};
            4: t = '{hi, lo, mid};
            default: t = '{hi, mid, lo};
        endcase
        return t;
    endfunction

    // runs of samples settle onto a target from above so the filter can sit on an edge
    task automatic drive_phase(input int n_items);
        int run_left;
        int target;
        int cur_reading;
        int slot;
        run_left = 0;
        target   = 0;
        slot     = 0;
        cur_reading = 0;
        for (int i = 0; i < n_items; i++) begin
            if (slot == 0) begin
                if (run_left == 0) begin
                    target   = pick_reading();
                    run_left = $urandom_range(3, 6);
                    cur_reading = target + $urandom_range(0, 200);
                    if (cur_reading > 65535) cur_reading = 65535;
                end else begin
                    cur_reading = target;
                end
                run_left--;
            end
            offer_readings(make_triple(cur_reading));
            slot = (slot + 1) % TRIPLES_PER_SAMPLE;
        end
    endtask

    task automatic test_median_cases();
        offer_readings('{16'h0000, 16'h0000, 16'h0000});
        offer_readings('{16'hFFFF, 16'hFFFF, 16'hFFFF});
        offer_readings('{16'd1, 16'd2, 16'd3});
        offer_readings('{16'd3, 16'd2, 16'd1});
        offer_readings('{16'd2, 16'd3, 16'd1});
        offer_readings('{16'hFFFF, 16'h0000, 16'h8000});
        offer_readings('{16'h0000, 16'h8000, 16'h8000});
        offer_readings('{16'hFFFF, 16'h0000, 16'h0000});
    endtask

    // saturation both ways, out-of-range band count, unordered edges, zero window
    task automatic test_saturation_limits();
        settle();
        program_registers('{bin_count: 3'd7, boundary_one: 16'd6000, boundary_two: 16'd5000,
                            boundary_three: 16'd4000, boundary_four: 16'd3000,
                            baseline_offset: 16'hFFFF, window_len: 8'd0});
        repeat (4) offer_readings('{16'h0000, 16'h0000, 16'h0000});
        settle();
        program_registers('{bin_count: 3'd0, boundary_one: 16'h0000, boundary_two: 16'h0000,
                            boundary_three: 16'hFFFF, boundary_four: 16'hFFFF,
                            baseline_offset: 16'h0000, window_len: 8'd1});
        repeat (4) offer_readings('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    endtask

    task automatic test_window_shrink();
        cfg_t c;
        c = '{bin_count: 3'd5, boundary_one: 16'd2000, boundary_two: 16'd3000,
              boundary_three: 16'd4000, boundary_four: 16'd5000,
              baseline_offset: 16'd0, window_len: 8'd255};
        settle();
        program_registers(c);
        repeat (8) offer_readings('{16'd2500, 16'd2400, 16'd2600});
        settle();
        c.window_len = 8'd2;
        program_registers(c);
        repeat (4) offer_readings('{16'd4500, 16'd4600, 16'd4400});
    endtask

    task automatic test_random_windows();
        for (int p = 0; p < 6; p++) begin
            settle();
            program_registers(random_settings());
            drive_phase($urandom_range(80, 110));
        end
    endtask

    task automatic test_full_rate();
        settle();
        program_registers(random_settings());
        no_idle = 1'b1;
        drive_phase(40);
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        no_idle = 1'b1;
        drive_phase(48);
        no_idle = 1'b0;
    endtask

    // result side: random ready gaps, plus one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                gap = idle_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                mismatches++;
                $display("%0t: result transaction with none expected, actual %0d/%0d/%0d", $time,
                         m_data.filtered_sample, m_data.decision_valid, m_data.gesture_class);
            end else begin
                oldest_sample = pending_samples.pop_front();
                if (m_data.filtered_sample !== oldest_sample.filtered_sample
                        || m_data.decision_valid !== oldest_sample.decision_valid
                        || m_data.gesture_class !== oldest_sample.gesture_class) begin
                    mismatches++;
                    $display("%0t: sample/decision/class expected %0d/%0d/%0d actual %0d/%0d/%0d",
                             $time, oldest_sample.filtered_sample, oldest_sample.decision_valid,
                             oldest_sample.gesture_class, m_data.filtered_sample,
                             m_data.decision_valid, m_data.gesture_class);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_BIN_COUNT;
        cfg_wdata <= '0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        reset_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_median_cases();
        test_saturation_limits();
        test_window_shrink();
        test_random_windows();
        test_full_rate();
        test_backpressure();

        settle();
        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
